/* sv/bba_pkg.sv */
// ============================================================================
// Bitmap block allocator package
// Shared widths, defaults, status codes and divider request/response types.
// ============================================================================
package bba_pkg;

    localparam int ADDR_W   = 20;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;

    localparam int NUM_BLOCKS_DEF   = 1024;
    localparam int BLOCK_BYTES_DEF  = 512;
    localparam int SUPER_BLOCKS_DEF = 1;
    localparam int MAP_BLOCKS_DEF   = 1;

    localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(1024);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } bba_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BELOW   = 2'd2,
        ST_BEYOND  = 2'd3
    } bba_status_t;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
    } bba_div_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quotient;
    } bba_div_rsp_t;

endpackage

/* sv/bba_map_ram.sv */
// ============================================================================
// Bitmap row memory
// One write port, one read port, registered read data.
// ============================================================================
module bba_map_ram #(
    parameter int ROWS   = 32,
    parameter int WORD_W = 32,
    parameter int ROW_W  = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ROW_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ROW_W-1:0]  rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/bba_div.sv */
// ============================================================================
// Address-to-index divider
// Division by a constant through a precomputed reciprocal, with a registered result.
// ============================================================================
module bba_div #(
    parameter int DIVISOR = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bba_pkg::bba_div_req_t req,
    output bba_pkg::bba_div_rsp_t rsp
);

    import bba_pkg::*;

    // q = (x * ceil(2^(ADDR_W+L) / DIVISOR)) >> (ADDR_W+L), L = ceil(log2(DIVISOR))
    localparam int SHIFT_L = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int SHIFT   = ADDR_W + SHIFT_L;
    localparam int RECIP_W = ADDR_W + 2;
    localparam int PROD_W  = SHIFT + ADDR_W;
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    always_comb
    begin
        done_next = req.start;
        prod_next = prod_reg;
        if (req.start)
        begin
            prod_next = PROD_W'(req.dividend) * PROD_W'(RECIP_K);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            prod_reg <= '0;
        end
        else
        begin
            done_reg <= done_next;
            prod_reg <= prod_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = prod_reg[SHIFT +: ADDR_W];

endmodule

/* sv/bitmap_block_allocator.sv */
// ============================================================================
// Bitmap block allocator
// First-fit allocator over a one-bit-per-block used map with a used count.
// ============================================================================
// After reset the map memory is cleared one 32-bit row per cycle; in_ready
// stays low during that sweep, cfg writes are taken at any time. An allocate
// reads and tests one map row at a time (S_RD, then S_CHK) through the single
// map read port, starting at the lowest row that may hold a free block, and
// then forms the address in S_MUL and S_ADDR and loads the response in
// S_RESP. A free turns the byte address into a block index with a reciprocal
// multiply by the block size and then does a read-modify-write of one row;
// an address beyond the map or below the data area skips the row update. One
// request is in flight at a time; the next request is taken while the
// previous response waits at the output, and a response still held there
// stalls the next one in its last cycle.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS   = bba_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES  = bba_pkg::BLOCK_BYTES_DEF,
    parameter int SUPER_BLOCKS = bba_pkg::SUPER_BLOCKS_DEF,
    parameter int MAP_BLOCKS   = bba_pkg::MAP_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [bba_pkg::ADDR_W-1:0]    free_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bba_pkg::STATUS_W-1:0]  status,
    output logic [bba_pkg::ADDR_W-1:0]    block_address,
    output logic [bba_pkg::CNT_W-1:0]     used_blocks
);

    import bba_pkg::*;

    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int ROWS   = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LAST_BITS = NUM_BLOCKS - (ROWS - 1) * WORD_W;

    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [WORD_W-1:0] PAD_MASK =
        WORD_W'(~((64'd1 << LAST_BITS) - 64'd1));

    localparam longint unsigned DATA_BASE =
        (longint'(SUPER_BLOCKS) + longint'(MAP_BLOCKS)) * longint'(BLOCK_BYTES);
    localparam bit                BASE_BIG = (DATA_BASE >> ADDR_W) != 0;
    localparam logic [ADDR_W-1:0] BASE_MOD = ADDR_W'(DATA_BASE);
    localparam logic [ADDR_W-1:0] BB_MOD   = ADDR_W'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] NB_LIM   = ADDR_W'(NUM_BLOCKS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_MUL,
        S_ADDR,
        S_DIV,
        S_FRD,
        S_FCHK,
        S_RESP
    } state_t;

    function automatic logic [BIT_W:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_ptr_reg, row_ptr_next;
    logic [ROW_W-1:0]  hint_reg, hint_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic [CNT_W-1:0]  total_blocks_reg, total_blocks_next;
    bba_status_t       res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [ADDR_W-1:0] prod_reg, prod_next;
    bba_div_req_t      div_req_reg, div_req_next;
    logic              out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0] block_address_reg, block_address_next;
    logic [CNT_W-1:0]  used_blocks_reg, used_blocks_next;

    bba_div_rsp_t      div_rsp;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] scan_word;
    logic [BIT_W:0]    zero_hit;
    logic [WORD_W-1:0] bit_onehot;
    logic [ADDR_W-1:0] block_idx;

    bba_map_ram #(
        .ROWS   (ROWS),
        .WORD_W (WORD_W),
        .ROW_W  (ROW_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (row_ptr_reg),
        .rd_data (rd_data)
    );

    bba_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign scan_word  = (row_ptr_reg == LAST_ROW) ? (rd_data | PAD_MASK) : rd_data;
    assign zero_hit   = first_zero(scan_word);
    assign bit_onehot = WORD_W'(1) << bit_reg;
    assign block_idx  = ADDR_W'({row_ptr_reg, bit_reg});

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = row_ptr_reg;
        wr_data = '0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_CHK:
            begin
                wr_en   = zero_hit[BIT_W];
                wr_data = rd_data | (WORD_W'(1) << zero_hit[BIT_W-1:0]);
            end
            S_FCHK:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data & ~bit_onehot;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        row_ptr_next       = row_ptr_reg;
        hint_next          = hint_reg;
        bit_next           = bit_reg;
        used_count_next    = used_count_reg;
        total_blocks_next  = total_blocks_reg;
        res_status_next    = res_status_reg;
        res_addr_next      = res_addr_reg;
        prod_next          = prod_reg;
        div_req_next       = div_req_reg;
        div_req_next.start = 1'b0;
        out_valid_next     = out_valid_reg;
        status_next        = status_reg;
        block_address_next = block_address_reg;
        used_blocks_next   = used_blocks_reg;

        if (cfg_valid && cfg_ready)
        begin
            total_blocks_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                row_ptr_next = row_ptr_reg + ROW_W'(1);
                if (row_ptr_reg == LAST_ROW)
                begin
                    row_ptr_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                res_addr_next   = '0;
                res_status_next = ST_OK;
                if (in_valid)
                begin
                    if (command == CMD_ALLOC)
                    begin
                        if (used_count_reg >= total_blocks_reg)
                        begin
                            res_status_next = ST_NOSPACE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            row_ptr_next = hint_reg;
                            state_next   = S_RD;
                        end
                    end
                    else if (BASE_BIG || (free_address < BASE_MOD))
                    begin
                        res_status_next = ST_BELOW;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        div_req_next.start    = 1'b1;
                        div_req_next.dividend = free_address - BASE_MOD;
                        state_next            = S_DIV;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (zero_hit[BIT_W])
                begin
                    bit_next        = zero_hit[BIT_W-1:0];
                    hint_next       = row_ptr_reg;
                    used_count_next = used_count_reg + CNT_W'(1);
                    state_next      = S_MUL;
                end
                else if (row_ptr_reg == LAST_ROW)
                begin
                    res_status_next = ST_NOSPACE;
                    state_next      = S_RESP;
                end
                else
                begin
                    row_ptr_next = row_ptr_reg + ROW_W'(1);
                    state_next   = S_RD;
                end
            end
            S_MUL:
            begin
                prod_next  = ADDR_W'(block_idx * BB_MOD);
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                res_addr_next = BASE_MOD + prod_reg;
                state_next    = S_RESP;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient >= NB_LIM)
                    begin
                        res_status_next = ST_BEYOND;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        row_ptr_next = div_rsp.quotient[BIT_W +: ROW_W];
                        bit_next     = div_rsp.quotient[BIT_W-1:0];
                        state_next   = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (used_count_reg != '0)
                begin
                    used_count_next = used_count_reg - CNT_W'(1);
                end
                if (row_ptr_reg < hint_reg)
                begin
                    hint_next = row_ptr_reg;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    block_address_next = res_addr_reg;
                    used_blocks_next   = used_count_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            row_ptr_reg       <= '0;
            hint_reg          <= '0;
            bit_reg           <= '0;
            used_count_reg    <= '0;
            total_blocks_reg  <= TOTAL_RESET;
            res_status_reg    <= ST_OK;
            res_addr_reg      <= '0;
            prod_reg          <= '0;
            div_req_reg       <= '0;
            out_valid_reg     <= 1'b0;
            status_reg        <= '0;
            block_address_reg <= '0;
            used_blocks_reg   <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            row_ptr_reg       <= row_ptr_next;
            hint_reg          <= hint_next;
            bit_reg           <= bit_next;
            used_count_reg    <= used_count_next;
            total_blocks_reg  <= total_blocks_next;
            res_status_reg    <= res_status_next;
            res_addr_reg      <= res_addr_next;
            prod_reg          <= prod_next;
            div_req_reg       <= div_req_next;
            out_valid_reg     <= out_valid_next;
            status_reg        <= status_next;
            block_address_reg <= block_address_next;
            used_blocks_reg   <= used_blocks_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign block_address = block_address_reg;
    assign used_blocks   = used_blocks_reg;

    // one request in flight
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(used_count_reg) <= NUM_BLOCKS))
        else $error("used count beyond map size");

    a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (hint_reg <= LAST_ROW))
        else $error("scan hint beyond last row");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (block_address == '0))
        else $error("failed request returned an address");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_count_reg) |->
            ($past(state_reg) == S_CHK || $past(state_reg) == S_FCHK))
        else $error("used count changed outside map update");

endmodule
